FILE: sv/lirs_pkg.sv
// Shared types and constants for the linear interpolation resampler.
// No dependencies; used by lirs_ctrl, lirs_datapath and the top level.
package lirs_pkg;

   // width of the step register as seen on the configuration port
   localparam int CSR_WIDTH = 23;

   // controller to datapath
   typedef struct packed {
      logic load_cur;     // capture the accepted input beat
      logic issue;        // start one interpolated output at the current phase
      logic issue_last;   // this issue is the last of the run: wrap phase, shift samples
      logic drop;         // no output for this input: wrap phase, shift samples
   } lirs_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic ge_one;       // phase >= 1.0
      logic next_ge_one;  // phase + step >= 1.0
      logic issue_ok;     // product stage can take a new output
   } lirs_status_type;

endpackage

FILE: sv/linear_interp_resampler.sv
// Two-channel linear interpolation resampler. An input beat causes n results
// (n = 0..64, set by phase and step); no new beat is taken until all n are issued, or the
// beat is dropped when n = 0. The sequencer issues one result per cycle, except while a full
// result pipeline is held by rsp_tready, into a multiply stage and a sum/saturate stage; the
// first result of a beat passes the sequencer state and both stage registers to rsp_tvalid.
// Synchronous reset: phase and previous samples zero, step 1.0, result pipeline empty.
// Depends on lirs_pkg, lirs_ctrl, lirs_datapath.
module linear_interp_resampler #(
   parameter int SAMPLE_BITS = 16,
   parameter int FRAC_BITS   = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // configuration: step, FRAC_BITS fraction bits
   input  logic                                    csr_wen,
   input  logic [lirs_pkg::CSR_WIDTH-1:0]           csr_wdata,
   // input beats
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // fields from bit 0: sample_ch0, sample_ch1, zero pad
   input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]       req_tdata,
   // result beats
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // fields from bit 0: out_ch0, out_ch1, zero pad
   output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]       rsp_tdata,
   // last_of_run
   output logic                                    rsp_tlast
);

   localparam int TDW = ((2*SAMPLE_BITS+7)/8)*8;

   lirs_pkg::lirs_cmd_type    cmd;
   lirs_pkg::lirs_status_type status;
   logic signed [SAMPLE_BITS-1:0] out_ch0, out_ch1;

   lirs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lirs_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .FRAC_BITS   (FRAC_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .in_ch0    ($signed(req_tdata[SAMPLE_BITS-1:0])),
      .in_ch1    ($signed(req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS])),
      .cmd       (cmd),
      .status    (status),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_ch0   (out_ch0),
      .out_ch1   (out_ch1),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = TDW'({out_ch1, out_ch0});

endmodule

FILE: sv/lirs_ctrl.sv
// Sequencer for the linear interpolation resampler.
// Depends on lirs_pkg for the command and status structs.
module lirs_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  lirs_pkg::lirs_status_type status,
   output lirs_pkg::lirs_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_cur = 1'b1;
               state_in     = ST_RUN;
            end
         end
         ST_RUN: begin
            if (status.ge_one) begin
               // downsampling case: phase already past this input
               cmd.drop = 1'b1;
               state_in = ST_IDLE;
            end else if (status.issue_ok) begin
               cmd.issue = 1'b1;
               if (status.next_ge_one) begin
                  cmd.issue_last = 1'b1;
                  state_in       = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: sv/lirs_datapath.sv
// Datapath: step register, phase accumulator, sample registers and a two-stage
// multiply / sum-saturate pipeline feeding the result beat. Depends on lirs_pkg.
module lirs_datapath #(
   parameter int SAMPLE_BITS = 16,
   parameter int FRAC_BITS   = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wen,
   input  logic [lirs_pkg::CSR_WIDTH-1:0] csr_wdata,
   input  logic signed [SAMPLE_BITS-1:0] in_ch0,
   input  logic signed [SAMPLE_BITS-1:0] in_ch1,
   input  lirs_pkg::lirs_cmd_type         cmd,
   output lirs_pkg::lirs_status_type      status,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [SAMPLE_BITS-1:0] out_ch0,
   output logic signed [SAMPLE_BITS-1:0] out_ch1,
   output logic                          out_last
);

   localparam int S  = SAMPLE_BITS;
   localparam int F  = FRAC_BITS;
   localparam int PW = F + 7;                      // phase holds up to 1 + 64
   localparam int CW = (lirs_pkg::CSR_WIDTH > PW) ? lirs_pkg::CSR_WIDTH : PW;
   localparam int WW = F + 2;                      // signed weight, 0..1.0
   localparam int MW = S + WW;                     // product width
   localparam int QW = S + 2;                      // scaled term / sum width

   localparam logic [PW-1:0] ONE      = PW'(1) << F;
   localparam logic [CW-1:0] STEP_MIN = CW'(1) << (F - 6);
   localparam logic [CW-1:0] STEP_MAX = CW'(1) << (F + 6);
   localparam logic [WW-1:0] ONE_W    = WW'(1) << F;
   localparam logic [MW-1:0] BIAS     = (MW'(1) << F) - MW'(1);
   localparam logic signed [QW-1:0] SAT_HI = {3'b000, {(S-1){1'b1}}};
   localparam logic signed [QW-1:0] SAT_LO = {3'b111, {(S-1){1'b0}}};

   logic [PW-1:0] step_ff, phase_ff, phase_in, phase_sum;
   logic [CW-1:0] csr_wide, step_clamped;
   logic signed [S-1:0] prev0_ff, prev1_ff, cur0_ff, cur1_ff;

   // config write, clamped to [1/64, 64]
   always_comb begin
      csr_wide = CW'(csr_wdata);
      if (csr_wide < STEP_MIN) begin
         step_clamped = STEP_MIN;
      end else if (csr_wide > STEP_MAX) begin
         step_clamped = STEP_MAX;
      end else begin
         step_clamped = csr_wide;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ONE;
      end else if (csr_wen) begin
         step_ff <= step_clamped[PW-1:0];
      end
   end

   // phase accumulator
   assign phase_sum = phase_ff + step_ff;

   always_comb begin
      phase_in = phase_ff;
      if (cmd.drop) begin
         phase_in = phase_ff - ONE;
      end else if (cmd.issue_last) begin
         phase_in = phase_sum - ONE;
      end else if (cmd.issue) begin
         phase_in = phase_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         prev0_ff <= '0;
         prev1_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         if (cmd.drop || cmd.issue_last) begin
            prev0_ff <= cur0_ff;
            prev1_ff <= cur1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_cur) begin
         cur0_ff <= in_ch0;
         cur1_ff <= in_ch1;
      end
   end

   // pipeline handshake
   logic p_valid_ff, p_valid_in, o_valid_ff, o_valid_in, o_adv;
   assign o_adv      = !o_valid_ff || out_ready;
   assign p_valid_in = cmd.issue || (p_valid_ff && !o_adv);
   assign o_valid_in = (p_valid_ff && o_adv) || (o_valid_ff && !out_ready);

   assign status.ge_one      = (phase_ff >= ONE);
   assign status.next_ge_one = (phase_sum >= ONE);
   assign status.issue_ok    = !p_valid_ff || o_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= p_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   // stage 1: four products, weights w and 1-w
   logic signed [WW-1:0] w_cur, w_prev;
   logic signed [MW-1:0] pa0_in, pb0_in, pa1_in, pb1_in;
   logic signed [MW-1:0] pa0_ff, pb0_ff, pa1_ff, pb1_ff;
   logic                 p_last_ff;

   always_comb begin
      w_cur  = $signed({2'b00, phase_ff[F-1:0]});
      w_prev = $signed(ONE_W - WW'(phase_ff[F-1:0]));
      pa0_in = prev0_ff * w_prev;
      pb0_in = cur0_ff * w_cur;
      pa1_in = prev1_ff * w_prev;
      pb1_in = cur1_ff * w_cur;
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         pa0_ff    <= pa0_in;
         pb0_ff    <= pb0_in;
         pa1_ff    <= pa1_in;
         pb1_ff    <= pb1_in;
         p_last_ff <= cmd.issue_last;
      end
   end

   // stage 2: shift right with truncation toward zero, sum, saturate
   function automatic logic signed [QW-1:0] scale_term(input logic signed [MW-1:0] p);
      logic [MW-1:0] biased;
      biased = p + (p[MW-1] ? BIAS : '0);
      return $signed(biased[F+QW-1:F]);
   endfunction

   function automatic logic signed [S-1:0] sat_sum(input logic signed [QW-1:0] a,
                                                   input logic signed [QW-1:0] b);
      logic signed [QW-1:0] r;
      r = a + b;
      if (r > SAT_HI) begin
         r = SAT_HI;
      end else if (r < SAT_LO) begin
         r = SAT_LO;
      end
      return r[S-1:0];
   endfunction

   logic signed [S-1:0] o_ch0_ff, o_ch1_ff;
   logic                o_last_ff;

   always_ff @(posedge clock) begin
      if (p_valid_ff && o_adv) begin
         o_ch0_ff  <= sat_sum(scale_term(pa0_ff), scale_term(pb0_ff));
         o_ch1_ff  <= sat_sum(scale_term(pa1_ff), scale_term(pb1_ff));
         o_last_ff <= p_last_ff;
      end
   end

   assign out_valid = o_valid_ff;
   assign out_ch0   = o_ch0_ff;
   assign out_ch1   = o_ch1_ff;
   assign out_last  = o_last_ff;

endmodule
